/* sv/pwsp_pkg.sv */
`timescale 1ns / 1ps

package pwsp_pkg;

	// Widths of the result fields
	localparam int KIND_W   = 4;
	localparam int ID_W     = 29;
	localparam int VALUE_W  = 64;
	localparam int CNT_W    = 4;

	// Default limit on varint length in bytes
	localparam int MAX_VARINT_BYTES_DEF = 10;

	// Result queue geometry
	localparam int QDEPTH = 4;
	localparam int QPTR_W = 2;
	localparam int QCNT_W = 3;

	// Packed stream widths
	localparam int IN_TDATA_W  = 8;
	localparam int OUT_TDATA_W = 96;
	localparam int OUT_TUSER_W = 5;

	// Parser phase
	typedef enum logic [2:0] {
		PH_TAG     = 3'd0,
		PH_VARINT  = 3'd1,
		PH_FIXED   = 3'd2,
		PH_LENHDR  = 3'd3,
		PH_PAYLOAD = 3'd4
	} phase_t;

	// Wire types of the tag
	localparam logic [2:0] WT_VINT   = 3'd0;
	localparam logic [2:0] WT_FIX64  = 3'd1;
	localparam logic [2:0] WT_LEN    = 3'd2;
	localparam logic [2:0] WT_FIX32  = 3'd5;

	// Result kinds
	typedef enum logic [KIND_W-1:0] {
		K_VARINT   = 4'd0,
		K_FIX64    = 4'd1,
		K_LENHDR   = 4'd2,
		K_PAYLOAD  = 4'd3,
		K_FIX32    = 4'd4,
		K_MSG_OK   = 4'd5,
		K_BAD_WIRE = 4'd6,
		K_TRUNC    = 4'd7,
		K_OVERLONG = 4'd8
	} kind_t;

	typedef struct packed {
		kind_t               kind;
		logic [ID_W-1:0]     field_id;
		logic [VALUE_W-1:0]  field_value;
		logic                payload_end;
		logic                message_end;
	} pwsp_result_t;

	// Push strobes from the decoder to the result queue
	typedef struct packed {
		logic vld0;
		logic vld1;
	} pwsp_push_t;

	function automatic pwsp_result_t make_result(kind_t k, logic [ID_W-1:0] id,
			logic [VALUE_W-1:0] v, logic pe, logic me);
		pwsp_result_t r;
		r.kind        = k;
		r.field_id    = id;
		r.field_value = v;
		r.payload_end = pe;
		r.message_end = me;
		return r;
	endfunction

endpackage

/* sv/pwsp_decode.sv */
`timescale 1ns / 1ps

module pwsp_decode import pwsp_pkg::*; #(
	parameter int MAX_VARINT_BYTES = MAX_VARINT_BYTES_DEF
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         take,
	input  logic [7:0]   in_byte,
	input  logic         final_byte,
	output pwsp_push_t   push,
	output pwsp_result_t res0,
	output pwsp_result_t res1
);

	localparam logic [CNT_W-1:0] LAST_CNT = CNT_W'(MAX_VARINT_BYTES - 1);

	phase_t              phase_q,   phase_n;
	logic [2:0]          wire_q,    wire_n;
	logic [ID_W-1:0]     tag_q,     tag_n;
	logic [VALUE_W-1:0]  acc_q,     acc_n;
	logic [CNT_W-1:0]    cnt_q,     cnt_n;
	logic [VALUE_W-1:0]  left_q,    left_n;
	logic                skip_q,    skip_n;

	logic                more;
	logic                err;
	logic [6:0]          shamt7;
	logic [6:0]          shamt8;
	logic [VALUE_W-1:0]  vacc;
	logic [CNT_W-1:0]    cnt_inc;
	logic [CNT_W-1:0]    need;

	// Per-byte decode: next state and up to two results
	always_comb begin
		phase_n = phase_q;
		wire_n  = wire_q;
		tag_n   = tag_q;
		acc_n   = acc_q;
		cnt_n   = cnt_q;
		left_n  = left_q;
		skip_n  = skip_q;
		push    = '0;
		res0    = '0;
		res1    = '0;
		err     = 1'b0;
		more    = in_byte[7];
		shamt7  = 7'({3'b000, cnt_q} * 7'd7);
		shamt8  = {cnt_q, 3'b000};
		cnt_inc = cnt_q + CNT_W'(1);
		need    = (wire_q == WT_FIX64) ? CNT_W'(8) : CNT_W'(4);
		vacc    = acc_q | (VALUE_W'(in_byte[6:0]) << shamt7);

		if (skip_q) begin
			// drop bytes up to the end of the message
			if (final_byte) begin
				phase_n = PH_TAG;
				wire_n  = '0;
				tag_n   = '0;
				acc_n   = '0;
				cnt_n   = '0;
				left_n  = '0;
				skip_n  = 1'b0;
			end
		end else begin
			case (phase_q)
				PH_FIXED: begin
					acc_n = acc_q | (VALUE_W'(in_byte) << shamt8);
					cnt_n = cnt_inc;
					if (cnt_inc >= need) begin
						push.vld0 = 1'b1;
						res0 = make_result((wire_q == WT_FIX64) ? K_FIX64 : K_FIX32,
							tag_q, acc_n, 1'b0, 1'b0);
						acc_n   = '0;
						cnt_n   = '0;
						phase_n = PH_TAG;
					end
				end
				PH_PAYLOAD: begin
					push.vld0 = 1'b1;
					res0 = make_result(K_PAYLOAD, tag_q, VALUE_W'(in_byte),
						left_q == VALUE_W'(1), 1'b0);
					if (left_q != '0)
						left_n = left_q - VALUE_W'(1);
					if (left_n == '0)
						phase_n = PH_TAG;
				end
				default: begin
					// varint byte of a tag, a value or a length
					if (more && cnt_q >= LAST_CNT) begin
						push.vld0 = 1'b1;
						res0 = make_result(K_OVERLONG,
							(phase_q == PH_TAG) ? '0 : tag_q, '0, 1'b0, 1'b1);
						err = 1'b1;
					end else begin
						acc_n = vacc;
						cnt_n = cnt_inc;
						if (!more) begin
							acc_n = '0;
							cnt_n = '0;
							case (phase_q)
								PH_VARINT: begin
									push.vld0 = 1'b1;
									res0 = make_result(K_VARINT, tag_q, vacc, 1'b0, 1'b0);
									phase_n = PH_TAG;
								end
								PH_LENHDR: begin
									push.vld0 = 1'b1;
									res0 = make_result(K_LENHDR, tag_q, vacc, 1'b0, 1'b0);
									if (vacc == '0) begin
										phase_n = PH_TAG;
									end else begin
										left_n  = vacc;
										phase_n = PH_PAYLOAD;
									end
								end
								default: begin
									wire_n = vacc[2:0];
									tag_n  = vacc[ID_W+2:3];
									case (vacc[2:0])
										WT_VINT:   phase_n = PH_VARINT;
										WT_FIX64:  phase_n = PH_FIXED;
										WT_FIX32:  phase_n = PH_FIXED;
										WT_LEN:    phase_n = PH_LENHDR;
										default: begin
											push.vld0 = 1'b1;
											res0 = make_result(K_BAD_WIRE, vacc[ID_W+2:3], '0,
												1'b0, 1'b1);
											err = 1'b1;
										end
									endcase
								end
							endcase
						end
					end
				end
			endcase

			if (err) begin
				// abandon the message, skip the rest unless it ends here
				phase_n = PH_TAG;
				wire_n  = '0;
				tag_n   = '0;
				acc_n   = '0;
				cnt_n   = '0;
				left_n  = '0;
				skip_n  = !final_byte;
			end else if (final_byte) begin
				// close the message: ok, or truncated inside a field
				if (push.vld0)
					push.vld1 = 1'b1;
				else
					push.vld0 = 1'b1;
				if (phase_n == PH_TAG && cnt_n == '0) begin
					if (push.vld1)
						res1 = make_result(K_MSG_OK, '0, '0, 1'b0, 1'b1);
					else
						res0 = make_result(K_MSG_OK, '0, '0, 1'b0, 1'b1);
				end else begin
					if (push.vld1)
						res1 = make_result(K_TRUNC, (phase_n == PH_TAG) ? '0 : tag_n,
							'0, 1'b0, 1'b1);
					else
						res0 = make_result(K_TRUNC, (phase_n == PH_TAG) ? '0 : tag_n,
							'0, 1'b0, 1'b1);
				end
				phase_n = PH_TAG;
				wire_n  = '0;
				tag_n   = '0;
				acc_n   = '0;
				cnt_n   = '0;
				left_n  = '0;
				skip_n  = 1'b0;
			end
		end

		if (!take)
			push = '0;
	end

	// Advance parser state on each accepted byte
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_TAG;
			wire_q  <= '0;
			tag_q   <= '0;
			acc_q   <= '0;
			cnt_q   <= '0;
			left_q  <= '0;
			skip_q  <= 1'b0;
		end else if (take) begin
			phase_q <= phase_n;
			wire_q  <= wire_n;
			tag_q   <= tag_n;
			acc_q   <= acc_n;
			cnt_q   <= cnt_n;
			left_q  <= left_n;
			skip_q  <= skip_n;
		end
	end

`ifndef SYNTH
	a_second_needs_first: assert property (@(posedge clk) disable iff (!arst_n)
		push.vld1 |-> push.vld0)
		else $error("second result pushed without first");

	a_skip_at_tag: assert property (@(posedge clk) disable iff (!arst_n)
		skip_q |-> (phase_q == PH_TAG && cnt_q == '0))
		else $error("skipping with a field in progress");

	a_err_then_skip: assert property (@(posedge clk) disable iff (!arst_n)
		(take && !skip_q && push.vld0 && !final_byte &&
		(res0.kind == K_OVERLONG || res0.kind == K_BAD_WIRE)) |=> skip_q)
		else $error("error result did not start skipping");
`endif

endmodule

/* sv/pwsp_queue.sv */
`timescale 1ns / 1ps

module pwsp_queue import pwsp_pkg::*; (
	input  logic         clk,
	input  logic         arst_n,
	input  pwsp_push_t   push,
	input  pwsp_result_t res0,
	input  pwsp_result_t res1,
	output logic         room,
	output logic         out_valid,
	input  logic         out_ready,
	output pwsp_result_t out_res
);

	pwsp_result_t        mem_q [QDEPTH];
	logic [QPTR_W-1:0]   wr_q;
	logic [QPTR_W-1:0]   rd_q;
	logic [QCNT_W-1:0]   cnt_q;
	logic [QCNT_W-1:0]   n_push;
	logic                pop;
	logic [QPTR_W-1:0]   wr_idx0;
	logic [QPTR_W-1:0]   wr_idx1;

	assign n_push    = QCNT_W'(push.vld0) + QCNT_W'(push.vld1);
	assign out_valid = (cnt_q != '0);
	assign pop       = out_valid && out_ready;
	assign out_res   = mem_q[rd_q];
	// keep space for the two results one byte may produce
	assign room      = (cnt_q <= QCNT_W'(QDEPTH - 2));
	assign wr_idx0   = wr_q;
	assign wr_idx1   = wr_q + QPTR_W'(1);

	// Store pushed results
	always_ff @(posedge clk) begin
		if (push.vld0)
			mem_q[wr_idx0] <= res0;
		if (push.vld1)
			mem_q[wr_idx1] <= res1;
	end

	// Advance pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			wr_q  <= wr_q + QPTR_W'(n_push);
			if (pop)
				rd_q <= rd_q + QPTR_W'(1);
			cnt_q <= cnt_q + n_push - QCNT_W'(pop);
		end
	end

`ifndef SYNTH
	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= QCNT_W'(QDEPTH))
		else $error("result queue overflow");

	a_push_needs_room: assert property (@(posedge clk) disable iff (!arst_n)
		(push.vld0 || push.vld1) |-> $past(room) || (cnt_q <= QCNT_W'(QDEPTH - 2)))
		else $error("push while result queue lacks room");

	a_count_tracks: assert property (@(posedge clk) disable iff (!arst_n)
		(!push.vld0 && !push.vld1 && !pop) |=> $stable(cnt_q))
		else $error("queue count moved without a request");
`endif

endmodule

/* sv/protobuf_wire_stream_parser.sv */
`timescale 1ns / 1ps
// Results: a byte's results are written into the result queue when it is accepted and
// are offered on m_axis from there. Throughput: one byte per cycle while the queue has
// room; the four-entry result queue drains one result per cycle while m_axis_tready is
// high, so a byte that yields two results (a closing one on the final byte) outpaces the drain.
// Reset: arst_n clears parser state and the result queue; the block expects a tag.

module protobuf_wire_stream_parser import pwsp_pkg::*; #(
	parameter int MAX_VARINT_BYTES = MAX_VARINT_BYTES_DEF
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   s_axis_tvalid,
	output logic                   s_axis_tready,
	input  logic [IN_TDATA_W-1:0]  s_axis_tdata,   // [7:0] in_byte
	input  logic                   s_axis_tlast,   // final_byte
	output logic                   m_axis_tvalid,
	input  logic                   m_axis_tready,
	output logic [OUT_TDATA_W-1:0] m_axis_tdata,   // [28:0] field_id, [92:29] field_value
	output logic [OUT_TUSER_W-1:0] m_axis_tuser,   // [3:0] kind, [4] payload_end
	output logic                   m_axis_tlast    // message_end
);

	logic         take;
	logic         room;
	pwsp_push_t   push;
	pwsp_result_t res0;
	pwsp_result_t res1;
	pwsp_result_t out_res;

	assign s_axis_tready = room;
	assign take          = s_axis_tvalid && s_axis_tready;

	pwsp_decode #(
		.MAX_VARINT_BYTES(MAX_VARINT_BYTES)
	) u_decode (
		.clk        (clk),
		.arst_n     (arst_n),
		.take       (take),
		.in_byte    (s_axis_tdata[7:0]),
		.final_byte (s_axis_tlast),
		.push       (push),
		.res0       (res0),
		.res1       (res1)
	);

	pwsp_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.res0      (res0),
		.res1      (res1),
		.room      (room),
		.out_valid (m_axis_tvalid),
		.out_ready (m_axis_tready),
		.out_res   (out_res)
	);

	// Pack the result onto the master side
	assign m_axis_tdata = {3'b000, out_res.field_value, out_res.field_id};
	assign m_axis_tuser = {out_res.payload_end, out_res.kind};
	assign m_axis_tlast = out_res.message_end;

endmodule
